// ===== hw/rtl/arfc_pkg.sv =====
// Package for the auto-range false-color mapper: widths, fixed-point constants,
// word types and state encodings. No dependencies.
`timescale 1ns / 1ps

package arfc_pkg;

  // Field widths.
  localparam int SAMPLE_BITS = 16;
  localparam int COLOR_BITS  = 8;
  localparam int SPAN_BITS   = 15;
  localparam int CFG_IDX_W   = 2;

  // Bounds are Q2.21, eight fraction bits more than the samples.
  localparam int BOUND_BITS  = SAMPLE_BITS + 8;
  localparam int BOUND_ONE   = 1 << 21;

  // Normalizer widths: raw numerator/denominator and the clamped ratio.
  localparam int NUM_W       = BOUND_BITS + 2;
  localparam int DEN_W       = BOUND_BITS;

  // Fixed window -0.2..0.2 as (5*s + 8192) / 16384.
  localparam int FIX_GAIN    = 5;
  localparam int FIX_OFFSET  = 8192;
  localparam int FIX_DEN     = 16384;

  // Exponential smoothing, weight 655/65536.
  localparam int EMA_WEIGHT  = 655;
  localparam int EMA_SHIFT   = 16;
  localparam int DLT_W       = BOUND_BITS + 1;
  localparam int PROD_W      = BOUND_BITS + 12;
  localparam int NEW_W       = BOUND_BITS + 3;

  // Divider: quotient up to 2*M needs one bit more than a color.
  localparam int QUO_W       = COLOR_BITS + 1;
  localparam int DIVD_W      = BOUND_BITS + COLOR_BITS + 1;
  localparam int STEP_W      = $clog2(QUO_W + 1);
  localparam logic [COLOR_BITS-1:0] COLOR_MAX = COLOR_BITS'((1 << COLOR_BITS) - 1);

  // Queue between front and back (depth of at least two).
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Reset values of the configuration registers.
  localparam logic [SPAN_BITS-1:0] MIN_SPAN_RESET = SPAN_BITS'(819);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DYNAMIC_MODE = 2'd0,
    CFG_COLOR_MODE   = 2'd1,
    CFG_MIN_SPAN     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_LO,
    F_MUL_HI,
    F_SUM_HI,
    F_FIT
  } f_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } b_state_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] blue;
    logic                  last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic                 dynamic_mode;
    logic                 color_mode;
    logic [SPAN_BITS-1:0] min_span;
  } cfg_t;

  // One classified word: clamped ratio num/den plus what the back end needs.
  typedef struct packed {
    logic [DEN_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             color_mode;
    logic             last;
  } job_t;

endpackage

// ===== hw/rtl/arfc_queue.sv =====
// Short job queue that decouples the front end from the divider back end.
// Depends on arfc_pkg for job_t and the queue depth.
`timescale 1ns / 1ps

module arfc_queue
  import arfc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  job_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == QCNT_W'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("fill count did not follow a push");
`endif

endmodule

// ===== hw/rtl/arfc_front.sv =====
// Front end: accepts samples, normalizes them to a clamped ratio, tracks the
// frame extremes and runs the bound update at frame end. Depends on arfc_pkg.
`timescale 1ns / 1ps

module arfc_front
  import arfc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_data_i,
  output logic     push_o,
  output job_t     push_data_o,
  input  logic     full_i
);

  f_state_e fsm_q, fsm_d;

  logic signed [BOUND_BITS-1:0]  low_q, low_d;
  logic signed [BOUND_BITS-1:0]  high_q, high_d;
  logic signed [SAMPLE_BITS-1:0] fmin_q, fmin_d;
  logic signed [SAMPLE_BITS-1:0] fmax_q, fmax_d;
  logic                          open_q, open_d;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [NEW_W-1:0]       lo_new_q, lo_new_d;
  logic signed [NEW_W-1:0]       hi_new_q, hi_new_d;
  logic [SPAN_BITS-1:0]          span_q;

  logic                          busy;
  logic                          accept;
  logic                          start_upd;
  logic signed [SAMPLE_BITS-1:0] s;
  logic signed [NUM_W-1:0]       s_w, num_raw, den_raw, num_c, den_c;
  logic signed [DLT_W-1:0]       dlt;
  logic signed [PROD_W-1:0]      prod_sh;
  logic signed [NEW_W-1:0]       span_w, half_w, diff, centre, lo_fit, hi_fit;
  logic signed [NEW_W:0]         pair_sum;

  function automatic logic signed [BOUND_BITS-1:0] sat_bound(
    input logic signed [NEW_W-1:0] x
  );
    logic signed [NEW_W-1:0] hi_lim;
    logic signed [NEW_W-1:0] lo_lim;
    hi_lim = NEW_W'((BOUND_ONE * 0) + ((1 << (BOUND_BITS - 1)) - 1));
    lo_lim = -hi_lim - NEW_W'(1);
    if (x > hi_lim) begin
      return hi_lim[BOUND_BITS-1:0];
    end else if (x < lo_lim) begin
      return lo_lim[BOUND_BITS-1:0];
    end
    return x[BOUND_BITS-1:0];
  endfunction

  assign s      = in_data_i.sample;
  assign accept = in_valid_i && !in_stall_o;

  // Control outputs of the update sequencer.
  always_comb begin
    busy      = (fsm_q != F_IDLE);
    start_upd = accept && in_data_i.frame_end && cfg_i.dynamic_mode;
  end

  // Next state of the update sequencer.
  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      F_IDLE:   if (start_upd) fsm_d = F_MUL_LO;
      F_MUL_LO: fsm_d = F_MUL_HI;
      F_MUL_HI: fsm_d = F_SUM_HI;
      F_SUM_HI: fsm_d = F_FIT;
      F_FIT:    fsm_d = F_IDLE;
      default:  fsm_d = F_IDLE;
    endcase
  end

  assign in_stall_o = full_i || busy;

  // Normalize the sample to num/den and clamp to 0..1.
  always_comb begin
    s_w = NUM_W'(s);
    if (cfg_i.dynamic_mode) begin
      num_raw = (s_w <<< 8) - NUM_W'(low_q);
      den_raw = NUM_W'(high_q) - NUM_W'(low_q);
    end else begin
      num_raw = s_w * NUM_W'(FIX_GAIN) + NUM_W'(FIX_OFFSET);
      den_raw = NUM_W'(FIX_DEN);
    end
    num_c = num_raw;
    den_c = den_raw;
    if (den_raw <= 0 || num_raw <= 0) begin
      num_c = '0;
      if (den_raw <= 0) begin
        den_c = NUM_W'(1);
      end
    end
    if (num_c > den_c) begin
      num_c = den_c;
    end
  end

  assign push_o                 = accept;
  assign push_data_o.num        = num_c[DEN_W-1:0];
  assign push_data_o.den        = den_c[DEN_W-1:0];
  assign push_data_o.color_mode = cfg_i.color_mode;
  assign push_data_o.last       = in_data_i.frame_end;

  // Frame extremes; the frame-end sample still counts in its frame.
  always_comb begin
    fmin_d = fmin_q;
    fmax_d = fmax_q;
    open_d = open_q;
    if (accept) begin
      if (!open_q || s < fmin_q) fmin_d = s;
      if (!open_q || s > fmax_q) fmax_d = s;
      open_d = !in_data_i.frame_end;
    end
  end

  // Smoothing: new = old + floor(655 * (ext*256 - old) / 65536), one product a cycle.
  always_comb begin
    prod_sh = prod_q >>> EMA_SHIFT;
    if (fsm_q == F_MUL_LO) begin
      dlt = (DLT_W'(fmin_q) <<< 8) - DLT_W'(low_q);
    end else begin
      dlt = (DLT_W'(fmax_q) <<< 8) - DLT_W'(high_q);
    end
    prod_d   = PROD_W'(dlt) * PROD_W'(EMA_WEIGHT);
    lo_new_d = lo_new_q;
    hi_new_d = hi_new_q;
    if (fsm_q == F_MUL_HI) begin
      lo_new_d = NEW_W'(low_q) + NEW_W'(prod_sh);
    end
    if (fsm_q == F_SUM_HI) begin
      hi_new_d = NEW_W'(high_q) + NEW_W'(prod_sh);
    end
  end

  // Widen about the centre to the minimum span, then saturate.
  always_comb begin
    span_w   = $signed(NEW_W'({span_q, 8'd0}));
    half_w   = $signed(NEW_W'({span_q, 7'd0}));
    diff     = hi_new_q - lo_new_q;
    pair_sum = (NEW_W + 1)'(lo_new_q) + (NEW_W + 1)'(hi_new_q);
    centre   = NEW_W'(pair_sum >>> 1);
    lo_fit   = lo_new_q;
    hi_fit   = hi_new_q;
    if (diff < span_w) begin
      lo_fit = centre - half_w;
      hi_fit = centre + half_w;
    end
    low_d  = low_q;
    high_d = high_q;
    if (fsm_q == F_FIT) begin
      low_d  = sat_bound(lo_fit);
      high_d = sat_bound(hi_fit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q  <= F_IDLE;
      low_q  <= -BOUND_BITS'(BOUND_ONE);
      high_q <= BOUND_BITS'(BOUND_ONE);
      fmin_q <= '0;
      fmax_q <= '0;
      open_q <= 1'b0;
    end else begin
      fsm_q  <= fsm_d;
      low_q  <= low_d;
      high_q <= high_d;
      fmin_q <= fmin_d;
      fmax_q <= fmax_d;
      open_q <= open_d;
    end
  end

  // Update datapath registers.
  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    lo_new_q <= lo_new_d;
    hi_new_q <= hi_new_d;
    if (start_upd) begin
      span_q <= cfg_i.min_span;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q != F_IDLE) |-> in_stall_o) else $error("word taken during bound update");
  a_upd_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == F_MUL_LO) |-> $past(accept && in_data_i.frame_end && cfg_i.dynamic_mode))
    else $error("bound update without a dynamic frame end");
  a_bounds_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q != F_FIT) |=> ($stable(low_q) && $stable(high_q)))
    else $error("bounds moved outside the fit step");
`endif

endmodule

// ===== hw/rtl/arfc_back.sv =====
// Back end: restoring divider that turns num/den into a red/blue pair, and the
// output register. Depends on arfc_pkg.
`timescale 1ns / 1ps

module arfc_back
  import arfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  job_t      pop_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  b_state_e state_q, state_d;

  logic [DIVD_W-1:0]     rem_q, rem_d;
  logic [DIVD_W-1:0]     dsh_q, dsh_d;
  logic [QUO_W-1:0]      quo_q, quo_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  mode_q, last_q;
  logic                  out_valid_q;
  out_word_t             out_data_q;

  logic                  div_step;
  logic                  load;
  logic [DIVD_W-1:0]     nx;
  logic [COLOR_BITS-1:0] red, blue;

  // Control outputs of the divider sequencer.
  always_comb begin
    pop_o    = (state_q == B_IDLE) && !empty_i;
    div_step = (state_q == B_DIV);
    load     = (state_q == B_DONE) && (!out_valid_q || !out_stall_i);
  end

  // Next state of the divider sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!empty_i) state_d = B_DIV;
      B_DIV:   if (step_q == STEP_W'(QUO_W - 1)) state_d = B_DONE;
      B_DONE:  if (load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Dividend is M*num for the blend and 2*M*num for the split scheme.
  always_comb begin
    nx     = DIVD_W'(pop_data_i.num);
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (pop_o) begin
      if (pop_data_i.color_mode) begin
        rem_d = (nx << COLOR_BITS) - nx;
      end else begin
        rem_d = (nx << (COLOR_BITS + 1)) - (nx << 1);
      end
      dsh_d  = DIVD_W'(pop_data_i.den) << COLOR_BITS;
      quo_d  = '0;
      step_d = '0;
    end else if (div_step) begin
      if (rem_q >= dsh_q) begin
        rem_d = rem_q - dsh_q;
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      dsh_d  = dsh_q >> 1;
      step_d = step_q + 1'b1;
    end
  end

  // Color schemes from the quotient and the remainder.
  always_comb begin
    if (mode_q) begin
      red  = quo_q[COLOR_BITS-1:0];
      blue = COLOR_MAX - red - COLOR_BITS'(rem_q != '0);
    end else if (quo_q < QUO_W'(COLOR_MAX)) begin
      red  = '0;
      blue = quo_q[COLOR_BITS-1:0];
    end else begin
      red  = COLOR_BITS'(quo_q - QUO_W'(COLOR_MAX));
      blue = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider and output data registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    if (pop_o) begin
      mode_q <= pop_data_i.color_mode;
      last_q <= pop_data_i.last;
    end
    if (load) begin
      out_data_q.red           <= red;
      out_data_q.blue          <= blue;
      out_data_q.last_of_frame <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (step_q < STEP_W'(QUO_W))) else $error("divider overran");
  a_quo_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE) |-> (quo_q <= (QUO_W'(COLOR_MAX) << 1)))
    else $error("quotient above twice full scale");
  a_quo_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE && mode_q) |-> (quo_q <= QUO_W'(COLOR_MAX)))
    else $error("blend quotient above full scale");
`endif

endmodule

// ===== hw/rtl/auto_range_false_color_mapper.sv =====
// Auto-range false-color mapper: top level with configuration registers.
// Depends on arfc_pkg, arfc_front, arfc_queue and arfc_back.
//
// Usage:
//   Input words (sample, frame_end) arrive on in_valid_i/in_data_i and are
//   taken when in_stall_o is low. Each yields one output word (red, blue,
//   last_of_frame) on out_valid_o/out_data_o, taken when out_stall_i is low.
//   Configuration writes use cfg_valid_i with cfg_index_i/cfg_data_i and are
//   always ready: 0 dynamic_mode, 1 color_mode, 2 min_span.
// Timing:
//   An accepted word passes through the job queue to the back end's
//   restoring divider, which forms COLOR_BITS+1 quotient bits per word and
//   takes the next word only after the last is loaded into the output register.
//   A frame-end word in dynamic mode starts a bound update in the front end
//   (F_MUL_LO, F_MUL_HI, F_SUM_HI, F_FIT), during which in_stall_o stays high.
// Reset:
//   Bounds return to -1.0/+1.0, the frame tracker and queue empty, and the
//   registers to dynamic mode, blend scheme and min_span 819.
// Stalls:
//   A stalled output word holds; the two-entry queue keeps taking input until
//   it fills, then in_stall_o rises.
`timescale 1ns / 1ps

module auto_range_false_color_mapper
  import arfc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SPAN_BITS-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_empty;
  job_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dynamic_mode <= 1'b1;
      cfg_q.color_mode   <= 1'b1;
      cfg_q.min_span     <= MIN_SPAN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DYNAMIC_MODE: cfg_q.dynamic_mode <= cfg_data_i[0];
        CFG_COLOR_MODE:   cfg_q.color_mode   <= cfg_data_i[0];
        CFG_MIN_SPAN:     cfg_q.min_span     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  arfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (q_push),
    .push_data_o (q_wdata),
    .full_i      (q_full)
  );

  arfc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  arfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .pop_data_i  (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
